// File: hw/rtl/bclru_pkg.sv
// Package for the big-block cache tag and LRU controller.
// Holds the controller state type; no dependencies.
`timescale 1ns / 1ps
package bclru_pkg;
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CHECK,
    ST_DECIDE,
    ST_RD_NBR,
    ST_WAIT_NBR,
    ST_RELINK,
    ST_OUT
  } state_e;
endpackage

// File: hw/rtl/block_cache_lru_tag_controller.sv
// Top level of the big-block cache tag and LRU controller.
// Depends on bclru_pkg and bclru_ram.
//
//  channel  | direction | signals
//  ---------+-----------+-----------------------------------------------------
//  request  | in        | in_valid_i, in_ready_o, kind_i, sector_address_i,
//           |           | sectors_remaining_i
//  result   | out       | out_valid_o, out_ready_i, big_block_o, slot_o, ...
//
// Each request is handled alone. The tag memory is read one slot per cycle,
// scanning at most the slots in use, all SLOTS with a full cache, and a hit
// ends the scan early; the sequential tag scan through the single read port
// bounds the time from one accepted request to the next.
// The LRU list is kept as two link memories, updated by read-modify-write.
// Reset clears the fill count and the list ends; memories need no clearing.
// A stalled result holds in the output registers; no request is taken then.
`timescale 1ns / 1ps
module block_cache_lru_tag_controller import bclru_pkg::*; #(
  parameter int SLOTS           = 1024,
  parameter int SECTORS_PER_BIG = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] sector_address_i,
  input  logic [31:0] sectors_remaining_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [24:0] big_block_o,
  output logic [9:0]  slot_o,
  output logic [6:0]  offset_sectors_o,
  output logic [7:0]  chunk_sectors_o,
  output logic        hit_o,
  output logic        recycled_o,
  output logic        load_first_o,
  output logic        write_back_o
);
  localparam int SW = $clog2(SLOTS);
  localparam int OW = $clog2(SECTORS_PER_BIG);
  localparam int TW = 32 - OW;
  localparam int CW = OW + 1;

  state_e state_q, state_d;

  logic [SW:0]   used_q;
  logic [SW-1:0] mru_q, lru_q, mru_d, lru_d;
  logic [SW:0]   idx_q, idx_d;
  logic [SW-1:0] slot_q, slot_d;
  logic          kind_q, hit_q, hit_d, rec_q, rec_d;
  logic [TW-1:0] bb_q;
  logic [OW-1:0] off_q;
  logic [CW-1:0] chunk_q;
  logic [SW-1:0] o_q, n_q;

  // Tag memory port signals.
  logic          tag_we;
  logic [SW-1:0] tag_ra;
  logic [TW-1:0] tag_rd;
  // Link memories.
  logic          nl_we, ol_we, nl_we2;
  logic [SW-1:0] nl_wa, ol_wa, nl_wd, ol_wd, nl_ra, ol_ra, nl_rd, ol_rd;
  logic          nl_we_m, ol_we_m;
  logic [SW-1:0] nl_wa_m, nl_wd_m, ol_wa_m, ol_wd_m;

  bclru_ram #(.Width(TW), .Depth(SLOTS)) u_tags (
    .clk_i, .we_i(tag_we), .waddr_i(slot_q), .wdata_i(bb_q),
    .raddr_i(tag_ra), .rdata_o(tag_rd));
  bclru_ram #(.Width(SW), .Depth(SLOTS)) u_newer (
    .clk_i, .we_i(nl_we_m), .waddr_i(nl_wa_m), .wdata_i(nl_wd_m),
    .raddr_i(nl_ra), .rdata_o(nl_rd));
  bclru_ram #(.Width(SW), .Depth(SLOTS)) u_older (
    .clk_i, .we_i(ol_we_m), .waddr_i(ol_wa_m), .wdata_i(ol_wd_m),
    .raddr_i(ol_ra), .rdata_o(ol_rd));

  // Chunk split from the raw request.
  logic [31:0]   rem_eff;
  logic [CW-1:0] room;
  logic [CW-1:0] chunk_in;
  always_comb begin
    rem_eff = (sectors_remaining_i == 32'd0) ? 32'd1 : sectors_remaining_i;
    room = CW'(SECTORS_PER_BIG) - {1'b0, sector_address_i[OW-1:0]};
    chunk_in = {{(CW-1){1'b0}}, 1'b1};
    if (kind_i) begin
      chunk_in = (rem_eff < 32'(room)) ? rem_eff[CW-1:0] : room;
    end
  end

  wire accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  // The scan index runs one slot ahead of the returned tag, as read data is registered.
  assign tag_ra = idx_q[SW-1:0];
  wire [SW:0] chk_idx = idx_q - 1'b1;
  wire        tag_match = (tag_rd == bb_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept) state_d = (used_q == '0) ? ST_DECIDE : ST_SEARCH;
      ST_SEARCH:   state_d = ST_CHECK;
      ST_CHECK: begin
        if (tag_match || idx_q >= used_q) state_d = ST_DECIDE;
      end
      ST_DECIDE:   state_d = ST_RD_NBR;
      ST_RD_NBR:   state_d = ST_WAIT_NBR;
      ST_WAIT_NBR: state_d = ST_RELINK;
      ST_RELINK:   state_d = ST_OUT;
      ST_OUT:      if (out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    idx_d  = idx_q;
    slot_d = slot_q;
    hit_d  = hit_q;
    rec_d  = rec_q;
    mru_d  = mru_q;
    lru_d  = lru_q;
    tag_we = 1'b0;
    nl_we = 1'b0; ol_we = 1'b0; nl_we2 = 1'b0;
    nl_wa = '0; nl_wd = '0; ol_wa = '0; ol_wd = '0;
    nl_ra = slot_q;
    ol_ra = slot_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        hit_d = 1'b0;
        rec_d = 1'b0;
      end
      ST_SEARCH: idx_d = idx_q + 1'b1;
      ST_CHECK: begin
        if (tag_match) begin
          hit_d  = 1'b1;
          slot_d = chk_idx[SW-1:0];
        end else if (idx_q < used_q) begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!hit_q) begin
          if (used_q < (SW+1)'(SLOTS)) begin
            slot_d = used_q[SW-1:0];
          end else begin
            slot_d = lru_q;
            rec_d  = 1'b1;
          end
        end
      end
      ST_RD_NBR: ;
      ST_WAIT_NBR: ;
      ST_RELINK: begin
        tag_we = !hit_q;
        if (!hit_q && !rec_q) begin
          if (used_q == '0) begin
            mru_d = slot_q;
            lru_d = slot_q;
          end else begin
            ol_we = 1'b1; ol_wa = slot_q; ol_wd = mru_q;
            nl_we = 1'b1; nl_wa = mru_q;  nl_wd = slot_q;
            mru_d = slot_q;
          end
        end else if (slot_q != mru_q) begin
          // Unlink, then push on the most-recent end.
          if (slot_q == lru_q) begin
            lru_d = n_q;
          end else begin
            nl_we2 = 1'b1;
          end
          ol_we = 1'b1; ol_wa = slot_q; ol_wd = mru_q;
          nl_we = 1'b1; nl_wa = mru_q;  nl_wd = slot_q;
          mru_d = slot_q;
        end
      end
      default: ;
    endcase
  end

  // Single write port per link memory: the unlink writes are registered and go in the next cycle.
  logic          fix_q;
  logic [SW-1:0] fo_q, fn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      mru_q   <= '0;
      lru_q   <= '0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      rec_q   <= 1'b0;
      fix_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mru_q   <= mru_d;
      lru_q   <= lru_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      rec_q   <= rec_d;
      fix_q   <= nl_we2;
      if (state_q == ST_RELINK && !hit_q && !rec_q) used_q <= used_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (accept) begin
      kind_q  <= kind_i;
      bb_q    <= sector_address_i[31:OW];
      off_q   <= sector_address_i[OW-1:0];
      chunk_q <= chunk_in;
    end
    if (state_q == ST_WAIT_NBR) begin
      o_q <= ol_rd;
      n_q <= nl_rd;
    end
    fo_q <= o_q;
    fn_q <= n_q;
  end

  // The deferred unlink lands in ST_OUT, where no other link write happens.
  // The o/n neighbours are distinct from slot and mru updates above, except
  // n == mru, whose older link is the one the deferred write restores.
  always_comb begin
    nl_we_m = nl_we; nl_wa_m = nl_wa; nl_wd_m = nl_wd;
    ol_we_m = ol_we; ol_wa_m = ol_wa; ol_wd_m = ol_wd;
    if (fix_q) begin
      nl_we_m = 1'b1; nl_wa_m = fo_q; nl_wd_m = fn_q;
      ol_we_m = 1'b1; ol_wa_m = fn_q; ol_wd_m = fo_q;
    end
  end

  // Outputs.
  logic load;
  assign load = !hit_q && (!kind_q || chunk_q != CW'(SECTORS_PER_BIG));
  assign big_block_o      = 25'(bb_q);
  assign slot_o           = 10'(slot_q);
  assign offset_sectors_o = 7'(off_q);
  assign chunk_sectors_o  = 8'(chunk_q);
  assign hit_o            = hit_q;
  assign recycled_o       = rec_q;
  assign load_first_o     = load;
  assign write_back_o     = kind_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= (SW+1)'(SLOTS))
    else $error("fill count beyond slot count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !recycled_o)
    else $error("hit reported as recycled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    recycled_o && out_valid_o |-> used_q == (SW+1)'(SLOTS))
    else $error("recycle before cache full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fix_q |-> state_q == ST_OUT)
    else $error("deferred unlink outside result state");
endmodule

// File: hw/rtl/bclru_ram.sv
// Generic synchronous RAM with one write port, one read port and registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bclru_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
